/* src/lge_pkg.sv */
package lge_pkg;

  // Grid size. The grid is held as ROWS words of COLS bits.
  localparam int unsigned ROWS = 64;
  localparam int unsigned COLS = 64;

  localparam int unsigned ROW_AW = $clog2(ROWS);
  localparam int unsigned COL_AW = $clog2(COLS);

  // Field widths of the input and result beats.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned COL_W   = 6;
  localparam int unsigned GEN_W   = 31;

  localparam logic [GEN_W-1:0] GEN_MAX = {GEN_W{1'b1}};

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd3;

  // Generation sweep counter: runs from 0 up to ROWS + 2.
  localparam int unsigned CNT_W = $clog2(ROWS + 3);

  // Shared control of the row of cells.
  typedef struct packed {
    logic shift;     // move the three-row window down by one row
    logic keep_ld;   // capture the incoming bit as the saved old row 0
    logic use_keep;  // feed the saved old row 0 instead of memory data
  } cell_ctl_t;

endpackage

/* src/life_grid_engine_unit.sv */
// Toroidal Game of Life engine, rule B3/S23.
//
// The input channel (in_valid/in_ready) carries one operation per beat:
// write a cell, read a cell, clear the grid, or advance one generation.
// Every input beat produces exactly one result beat on the output channel
// (out_valid/out_ready), carrying the addressed cell after the operation
// and the saturating generation count.
//
// The grid lives in a row-wide memory, one word per row. A generation is
// computed by a ring of per-column cells, each holding a three-row window
// of its column; rows stream through the ring one per cycle, so the memory
// read port sets the speed. One item is worked on at a time; the next
// beat is accepted once the previous result has been placed in the output
// register.
//
// Reset (rst_n low at a clock edge) empties the grid through per-row valid
// bits and zeroes the counter at once; no clearing pass is needed. If the
// receiver stalls, the result waits in the output register and a finished
// item behind it holds until the register frees.
module life_grid_engine_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lge_pkg::OP_W-1:0]   in_operation,
  input  logic [lge_pkg::ROW_W-1:0]  in_row,
  input  logic [lge_pkg::COL_W-1:0]  in_col,
  input  logic                       in_cell_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_cell_out,
  output logic [lge_pkg::GEN_W-1:0]  out_generation
);

  import lge_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;  // read data of one row available
  localparam logic [1:0] ST_STEP = 2'd2;  // generation sweep in progress
  localparam logic [1:0] ST_FIN  = 2'd3;  // result ready for the output register

  localparam logic [CNT_W-1:0] CNT_KEEP    = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_LASTRD  = CNT_W'(ROWS - 1);
  localparam logic [CNT_W-1:0] CNT_FIRSTWR = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_WRAP    = CNT_W'(ROWS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(ROWS + 2);

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [GEN_W-1:0]  gen_r, gen_nxt;
  logic [ROWS-1:0]   row_vld_r, row_vld_nxt;
  logic              rd_vld_r;

  // The item being worked on.
  logic [OP_W-1:0]   op_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic              val_r;
  logic              inside_r;
  logic              res_r, res_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_cell_r;
  logic [GEN_W-1:0]  out_gen_r;

  logic              in_fire;
  logic              in_inside;
  logic              out_load;

  logic              wr_en;
  logic [ROW_AW-1:0] wr_addr;
  logic [COLS-1:0]   wr_data;
  logic              rd_en;
  logic [ROW_AW-1:0] rd_addr;
  logic [COLS-1:0]   rd_data;
  logic [COLS-1:0]   row_data;
  logic [COLS-1:0]   new_row;
  logic [COL_AW-1:0] col_idx;
  logic [ROW_AW-1:0] row_idx;

  cell_ctl_t         cell_ctl;
  logic [2:0]        win [COLS];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_inside = (32'(in_row) < ROWS) && (32'(in_col) < COLS);

  assign col_idx = COL_AW'(col_r);
  assign row_idx = ROW_AW'(row_r);

  // A row that has not been written since reset or clear reads as all dead.
  assign row_data = rd_data & {COLS{rd_vld_r}};

  // The result register loads when it is empty or being emptied this cycle.
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  lge_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Ring of column cells; the outermost columns are neighbours of each other.
  for (genvar c = 0; c < COLS; c++) begin : g_cell
    lge_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .in_bit    (row_data[c]),
      .left_win  (win[(c + COLS - 1) % COLS]),
      .right_win (win[(c + 1) % COLS]),
      .win       (win[c]),
      .nxt_bit   (new_row[c])
    );
  end

  // During a sweep the counter value k means: the memory data now on the
  // read port is row k - 1 (row ROWS - 1 when k is zero), and the window
  // currently held by the cells is centred on row k - 3, whose next state
  // is written back in this cycle. The final feed uses the saved old row 0,
  // since that row has already been overwritten in memory.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    gen_nxt       = gen_r;
    row_vld_nxt   = row_vld_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = row_idx;
    wr_data       = row_data;
    rd_en         = 1'b0;
    rd_addr       = ROW_AW'(in_row);
    cell_ctl      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt = 1'b0;
          case (in_operation)
            OP_CLEAR: begin
              row_vld_nxt = '0;
              gen_nxt     = '0;
              state_nxt   = ST_FIN;
            end
            OP_STEP: begin
              rd_en     = 1'b1;
              rd_addr   = ROW_AW'(ROWS - 1);
              cnt_nxt   = '0;
              state_nxt = ST_STEP;
            end
            default: begin
              rd_en     = 1'b1;
              state_nxt = ST_ACC;
            end
          endcase
        end
      end
      ST_ACC: begin
        if (op_r == OP_WRITE) begin
          res_nxt = inside_r && val_r;
          if (inside_r) begin
            wr_en                = 1'b1;
            wr_data[col_idx]     = val_r;
            row_vld_nxt[row_idx] = 1'b1;
          end
        end else begin
          res_nxt = inside_r && row_data[col_idx];
        end
        state_nxt = ST_FIN;
      end
      ST_STEP: begin
        cell_ctl.shift    = 1'b1;
        cell_ctl.keep_ld  = (cnt_r == CNT_KEEP);
        cell_ctl.use_keep = (cnt_r == CNT_WRAP);
        if (cnt_r <= CNT_LASTRD) begin
          rd_en   = 1'b1;
          rd_addr = ROW_AW'(cnt_r);
        end
        if (cnt_r >= CNT_FIRSTWR) begin
          wr_en                = 1'b1;
          wr_addr              = ROW_AW'(cnt_r - CNT_FIRSTWR);
          wr_data              = new_row;
          row_vld_nxt[wr_addr] = 1'b1;
          if (inside_r && (wr_addr == row_idx)) begin
            res_nxt = new_row[col_idx];
          end
        end
        if (cnt_r == CNT_LAST) begin
          if (gen_r != GEN_MAX) begin
            gen_nxt = gen_r + GEN_W'(1);
          end
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      gen_r       <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      gen_r       <= gen_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= row_vld_r[rd_addr];
    end
    if (in_fire) begin
      op_r     <= in_operation;
      row_r    <= in_row;
      col_r    <= in_col;
      val_r    <= in_cell_value;
      inside_r <= in_inside;
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_cell_r <= res_r;
      out_gen_r  <= gen_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_out   = out_cell_r;
  assign out_generation = out_gen_r;

`ifndef NO_ASSERTIONS
  // The memory is only written while an item is being worked on.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_en)
    else $error("grid memory written while idle");

  // The sweep counter never runs past the final write-back.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (cnt_r <= CNT_LAST))
    else $error("generation sweep counter overran");

  // A clear has emptied every row and zeroed the counter in the cycle after it is accepted.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_operation == OP_CLEAR)) |=> ((row_vld_r == '0) && (gen_r == '0)))
    else $error("clear did not empty the grid");

  // Only a clear can lower the generation count.
  a_gen_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && (in_operation == OP_CLEAR)) |=> (gen_r >= $past(gen_r)))
    else $error("generation count went backwards");
`endif

endmodule

/* src/lge_ram.sv */
module lge_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/lge_cell.sv */
module lge_cell (
  input  logic               clk,
  input  lge_pkg::cell_ctl_t ctl,
  input  logic               in_bit,
  input  logic [2:0]         left_win,
  input  logic [2:0]         right_win,
  output logic [2:0]         win,
  output logic               nxt_bit
);

  import lge_pkg::*;

  // One column of the grid: the bits of three consecutive rows, plus the
  // old value of row 0, which is needed again at the end of a sweep.
  logic       up_r;
  logic       mid_r;
  logic       dn_r;
  logic       keep_r;
  logic       feed;
  logic [3:0] live_cnt;

  assign feed = ctl.use_keep ? keep_r : in_bit;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      up_r  <= mid_r;
      mid_r <= dn_r;
      dn_r  <= feed;
    end
    if (ctl.keep_ld) begin
      keep_r <= in_bit;
    end
  end

  assign win = {up_r, mid_r, dn_r};

  assign live_cnt = 4'(left_win[2]) + 4'(left_win[1]) + 4'(left_win[0])
                  + 4'(right_win[2]) + 4'(right_win[1]) + 4'(right_win[0])
                  + 4'(up_r) + 4'(dn_r);

  // Birth on three, survival on two or three.
  assign nxt_bit = (live_cnt == 4'd3) || (mid_r && (live_cnt == 4'd2));

endmodule
